>>> rtl/hsa_pkg.sv
// Shared types and constants for the histogram shift alignment block.
`default_nettype none

package hsa_pkg;

    localparam int BIN_W   = 16;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int SHIFT_W = 6;
    localparam int ERR_W   = 40;
    localparam int SQ_W    = 32;

    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    // register indexes, decoded from paddr[2]
    localparam logic REG_BINS_USED_A = 1'b0;
    localparam logic REG_BINS_USED_B = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             en_a;
        logic             en_b;
        logic [IDX_W-1:0] index;
        logic [BIN_W-1:0] value;
    } wr_req_t;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] best_shift;
        logic [ERR_W-1:0]          best_error;
        logic                      found;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/hsa_hist_mem.sv
// One histogram store: synchronous RAM, one write port, one registered read port.
`default_nettype none

module hsa_hist_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [hsa_pkg::BIN_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [hsa_pkg::BIN_W-1:0] rdata
);

    logic [hsa_pkg::BIN_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/hsa_engine.sv
// Shift search engine: histogram memories, sequencer and square/accumulate pipeline.
`default_nettype none

module hsa_engine #(
    parameter int MAX_BINS      = 256,
    parameter int SHIFT_DIVISOR = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire hsa_pkg::wr_req_t          wr,
    input  wire logic                      start,
    input  wire logic [hsa_pkg::CNT_W-1:0] bins_used_a,
    input  wire logic [hsa_pkg::CNT_W-1:0] bins_used_b,
    input  wire logic                      res_ready,
    output logic                           idle,
    output logic                           res_valid,
    output hsa_pkg::result_t               res
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int NW = ($clog2(MAX_BINS + 1) > hsa_pkg::CNT_W) ?
                        $clog2(MAX_BINS + 1) : hsa_pkg::CNT_W;
    localparam int SW = NW + 1;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_BINS);
    // reciprocal of the divisor; exact for any count below 2**NW and divisor up to 64
    localparam int RECIP_SH = NW + 6;
    localparam int RW       = RECIP_SH + 1;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RECIP_SH) + 64'(SHIFT_DIVISOR) - 64'd1) / 64'(SHIFT_DIVISOR));

    hsa_pkg::state_t state_reg, state_next;

    logic [NW-1:0]                na_reg, na_next;
    logic [NW-1:0]                nb_reg, nb_next;
    logic [NW-1:0]                span_reg, span_next;
    logic signed [SW-1:0]         s_reg, s_next;
    logic [NW-1:0]                i_reg, i_next;
    logic [NW-1:0]                j_reg, j_next;
    logic [hsa_pkg::ERR_W-1:0]    acc_reg, acc_next;
    logic [hsa_pkg::ERR_W-1:0]    best_err_reg, best_err_next;
    logic signed [SW-1:0]         best_shift_reg, best_shift_next;
    logic                         found_reg, found_next;
    logic                         p1_valid_reg, p2_valid_reg;
    logic [hsa_pkg::SQ_W-1:0]     sq_reg;

    logic                         issue;
    logic [NW-1:0]                na_clamp, nb_clamp, ua_ext, ub_ext;
    logic [NW-1:0]                idx_ext;
    logic                         idx_ok;
    logic [hsa_pkg::BIN_W-1:0]    rd_a, rd_b, diff;
    logic [hsa_pkg::SQ_W-1:0]     sq_c;
    logic [hsa_pkg::ERR_W:0]      acc_sum;
    logic [hsa_pkg::ERR_W-1:0]    acc_sat;
    logic signed [SW-1:0]         s_neg;
    logic [SW-1:0]                s_inc;
    logic [NW+RW-1:0]             span_prod;
    logic [NW-1:0]                span_c;

    assign ua_ext   = NW'(bins_used_a);
    assign ub_ext   = NW'(bins_used_b);
    assign na_clamp = (ua_ext > MAX_N) ? MAX_N : ua_ext;
    assign nb_clamp = (ub_ext > MAX_N) ? MAX_N : ub_ext;

    // writes beyond the store depth are dropped
    assign idx_ext = NW'(wr.index);
    assign idx_ok  = idx_ext < MAX_N;

    hsa_hist_mem #(.DEPTH(MAX_BINS), .AW(AW)) u_mem_a (
        .aclk  (aclk),
        .we    (wr.en_a && idx_ok),
        .waddr (idx_ext[AW-1:0]),
        .wdata (wr.value),
        .raddr (i_reg[AW-1:0]),
        .rdata (rd_a)
    );

    hsa_hist_mem #(.DEPTH(MAX_BINS), .AW(AW)) u_mem_b (
        .aclk  (aclk),
        .we    (wr.en_b && idx_ok),
        .waddr (idx_ext[AW-1:0]),
        .wdata (wr.value),
        .raddr (j_reg[AW-1:0]),
        .rdata (rd_b)
    );

    assign diff    = (rd_a > rd_b) ? (rd_a - rd_b) : (rd_b - rd_a);
    assign sq_c    = diff * diff;
    assign acc_sum = {1'b0, acc_reg} + (hsa_pkg::ERR_W + 1)'(sq_reg);
    assign acc_sat = (acc_sum > {1'b0, hsa_pkg::ERR_MAX}) ? hsa_pkg::ERR_MAX
                                                         : acc_sum[hsa_pkg::ERR_W-1:0];
    assign s_neg     = -s_reg;
    assign s_inc     = s_reg + SW'(1);
    assign span_prod = (NW + RW)'(nb_reg) * (NW + RW)'(RECIP);
    assign span_c    = span_prod[RECIP_SH +: NW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hsa_pkg::ST_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        na_reg         <= na_next;
        nb_reg         <= nb_next;
        span_reg       <= span_next;
        s_reg          <= s_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        acc_reg        <= acc_next;
        best_err_reg   <= best_err_next;
        best_shift_reg <= best_shift_next;
        found_reg      <= found_next;
        sq_reg         <= sq_c;
    end

    always_comb begin
        state_next      = state_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        span_next       = span_reg;
        s_next          = s_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        acc_next        = acc_reg;
        best_err_next   = best_err_reg;
        best_shift_next = best_shift_reg;
        found_next      = found_reg;
        issue           = 1'b0;
        res_valid       = 1'b0;

        if (p2_valid_reg) begin
            acc_next = acc_sat;
        end

        unique case (state_reg)
            hsa_pkg::ST_IDLE: begin
                if (start) begin
                    na_next         = na_clamp;
                    nb_next         = nb_clamp;
                    span_next       = '0;
                    found_next      = 1'b0;
                    best_err_next   = '0;
                    best_shift_next = '0;
                    state_next      = hsa_pkg::ST_SPAN;
                end
            end
            // span = nb / divisor by reciprocal multiply
            hsa_pkg::ST_SPAN: begin
                span_next = span_c;
                if (span_c == '0) begin
                    state_next = hsa_pkg::ST_DONE;
                end else begin
                    s_next     = -$signed({1'b0, span_c});
                    state_next = hsa_pkg::ST_SETUP;
                end
            end
            hsa_pkg::ST_SETUP: begin
                i_next     = s_reg[SW-1] ? '0 : s_reg[NW-1:0];
                j_next     = s_reg[SW-1] ? s_neg[NW-1:0] : '0;
                acc_next   = '0;
                state_next = hsa_pkg::ST_RUN;
            end
            hsa_pkg::ST_RUN: begin
                if ((i_reg < na_reg) && (j_reg < nb_reg)) begin
                    issue  = 1'b1;
                    i_next = i_reg + NW'(1);
                    j_next = j_reg + NW'(1);
                end else begin
                    state_next = hsa_pkg::ST_DRAIN;
                end
            end
            hsa_pkg::ST_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = hsa_pkg::ST_CMP;
                end
            end
            hsa_pkg::ST_CMP: begin
                // strict compare keeps the lowest shift on ties
                if (!found_reg || (acc_reg < best_err_reg)) begin
                    best_err_next   = acc_reg;
                    best_shift_next = s_reg;
                end
                found_next = 1'b1;
                if (s_inc == {1'b0, span_reg}) begin
                    state_next = hsa_pkg::ST_DONE;
                end else begin
                    s_next     = $signed(s_inc);
                    state_next = hsa_pkg::ST_SETUP;
                end
            end
            hsa_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = hsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign idle           = (state_reg == hsa_pkg::ST_IDLE);
    assign res.best_shift = best_shift_reg[hsa_pkg::SHIFT_W-1:0];
    assign res.best_error = best_err_reg;
    assign res.found      = found_reg;

`ifndef SYNTHESIS
    a_pipe_empty_at_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hsa_pkg::ST_CMP) |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("shift scored while products still in flight");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == hsa_pkg::ST_IDLE))
        else $error("compute started while busy");

    a_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en_a || wr.en_b) |-> (state_reg == hsa_pkg::ST_IDLE))
        else $error("bin written during a search");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.found) |-> ((res.best_error == '0) && (res.best_shift == '0)))
        else $error("empty search returned nonzero result");
`endif

endmodule

`default_nettype wire

>>> rtl/histogram_shift_alignment.sv
// Top level: stream ports, APB register file and result output register.
// Loads are accepted back to back while no search runs.
// A compute item scores 2*S shifts, S = bins_used_b / SHIFT_DIVISOR; the single
// memory read port per histogram reads the overlap one bin pair per cycle.
// aresetn (synchronous, active low) clears control and sets both bin counts to
// 256; histogram contents are not cleared.
`default_nettype none

module histogram_shift_alignment #(
    parameter int MAX_BINS      = 256,
    parameter int SHIFT_DIVISOR = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] bin_index, [23:8] bin_value
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [5:0] best_shift, [45:6] best_error, pad
    output logic             m_tuser    // [0] found
);

    logic [hsa_pkg::CNT_W-1:0] bins_used_a_reg, bins_used_a_next;
    logic [hsa_pkg::CNT_W-1:0] bins_used_b_reg, bins_used_b_next;
    logic                      m_valid_reg, m_valid_next;
    hsa_pkg::result_t          m_data_reg, m_data_next;

    logic                      cfg_wr;
    logic                      s_accept;
    logic                      start;
    logic                      idle;
    logic                      res_valid;
    logic                      res_ready;
    hsa_pkg::result_t          res;
    hsa_pkg::wr_req_t          wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        bins_used_a_next = bins_used_a_reg;
        bins_used_b_next = bins_used_b_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                hsa_pkg::REG_BINS_USED_A: bins_used_a_next = pwdata[hsa_pkg::CNT_W-1:0];
                hsa_pkg::REG_BINS_USED_B: bins_used_b_next = pwdata[hsa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hsa_pkg::REG_BINS_USED_A: prdata = 32'(bins_used_a_reg);
            hsa_pkg::REG_BINS_USED_B: prdata = 32'(bins_used_b_reg);
            default:                  prdata = '0;
        endcase
    end

    assign s_tready = idle;
    assign s_accept = s_tvalid && s_tready;
    assign start    = s_accept && (s_tuser == hsa_pkg::OP_COMPUTE);
    assign wr.en_a  = s_accept && (s_tuser == hsa_pkg::OP_WRITE_A);
    assign wr.en_b  = s_accept && (s_tuser == hsa_pkg::OP_WRITE_B);
    assign wr.index = s_tdata[7:0];
    assign wr.value = s_tdata[23:8];

    hsa_engine #(
        .MAX_BINS      (MAX_BINS),
        .SHIFT_DIVISOR (SHIFT_DIVISOR)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (wr),
        .start       (start),
        .bins_used_a (bins_used_a_reg),
        .bins_used_b (bins_used_b_reg),
        .res_ready   (res_ready),
        .idle        (idle),
        .res_valid   (res_valid),
        .res         (res)
    );

    // output register frees the engine as soon as the result is captured
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_used_a_reg <= 9'd256;
            bins_used_b_reg <= 9'd256;
            m_valid_reg     <= 1'b0;
        end else begin
            bins_used_a_reg <= bins_used_a_next;
            bins_used_b_reg <= bins_used_b_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg.best_error, m_data_reg.best_shift};
    assign m_tuser  = m_data_reg.found;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the histogram shift alignment block.
module testbench;
    import hsa_pkg::*;

    localparam int BIN_LIMIT      = 256;
    localparam int SHIFT_DIV      = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PRESSURE_AFTER = 20;
    localparam int PRESSURE_HOLD  = 3000;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_ITEMS    = 55;

    class alignment_scoreboard;
        bit [BIN_W-1:0] hist_ref [BIN_LIMIT];
        bit [BIN_W-1:0] hist_oth [BIN_LIMIT];
        bit [CNT_W-1:0] bins_a = 9'd256;
        bit [CNT_W-1:0] bins_b = 9'd256;
        result_t        pending_results [$];
        int             mismatches = 0;

        function void set_bins(logic reg_sel, logic [CNT_W-1:0] value);
            if (reg_sel == REG_BINS_USED_A) bins_a = value;
            else bins_b = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // squared count difference summed over the overlap at one shift
        function logic [ERR_W-1:0] shift_cost(int na, int nb, int shift);
            int i, j;
            longint x, y, d;
            longint unsigned acc;
            i = (shift >= 0) ? shift : 0;
            j = (shift < 0) ? -shift : 0;
            acc = 0;
            while (i < na && j < nb) begin
                x = hist_ref[i];
                y = hist_oth[j];
                d = (x > y) ? x - y : y - x;
                acc += longint'(d * d);
                if (acc > ERR_MAX) acc = ERR_MAX;
                i++;
                j++;
            end
            return acc[ERR_W-1:0];
        endfunction

        function result_t best_alignment();
            int na, nb, span, best_s;
            bit hit;
            logic [ERR_W-1:0] err, best_e;
            result_t r;
            na = (bins_a > BIN_LIMIT) ? BIN_LIMIT : bins_a;
            nb = (bins_b > BIN_LIMIT) ? BIN_LIMIT : bins_b;
            span = nb / SHIFT_DIV;
            hit = 0;
            best_s = 0;
            best_e = '0;
            for (int s = -span; s < span; s++) begin
                err = shift_cost(na, nb, s);
                // strict compare keeps the lowest shift on ties
                if (!hit || err < best_e) begin
                    hit = 1;
                    best_e = err;
                    best_s = s;
                end
            end
            r.best_shift = best_s[SHIFT_W-1:0];
            r.best_error = best_e;
            r.found = hit;
            return r;
        endfunction

        function void note_item(logic [1:0] op, logic [IDX_W-1:0] idx, logic [BIN_W-1:0] val);
            if (op == OP_WRITE_A) hist_ref[idx] = val;
            else if (op == OP_WRITE_B) hist_oth[idx] = val;
            else if (op == OP_COMPUTE)
                pending_results.insert(pending_results.size(), best_alignment());
        endfunction

        function void check_result(logic [47:0] data, logic user);
            result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: shift %0d error %0d found %0b", $time,
                         $signed(data[5:0]), data[45:6], user);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (data[5:0] !== want.best_shift) begin
                $display("%0t: best_shift expected %0d actual %0d", $time,
                         want.best_shift, $signed(data[5:0]));
                mismatches++;
            end
            if (data[45:6] !== want.best_error) begin
                $display("%0t: best_error expected %0d actual %0d", $time,
                         want.best_error, data[45:6]);
                mismatches++;
            end
            if (user !== want.found) begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, user);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    alignment_scoreboard sb = new();
    int s_quiet = 0;
    int m_quiet = 0;
    int stall_cycles = 0;

    histogram_shift_alignment #(
        .MAX_BINS      (BIN_LIMIT),
        .SHIFT_DIVISOR (SHIFT_DIV)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones, and now and then a quiet stretch
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) quiet = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BIN_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return BIN_W'($urandom_range(0, 15));
        return BIN_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] rand_bin();
        if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, 63));
        return IDX_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [BIN_W-1:0] val);
        int gap;
        gap = pick_gap(s_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, idx};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // loads give no result, so allow the block to settle after the last one
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bins(input logic reg_sel, input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {23'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_bins(reg_sel, value);
        @(posedge aclk);
    endtask

    task automatic configure(input int na, input int nb);
        wait_idle();
        write_bins(REG_BINS_USED_A, na[CNT_W-1:0]);
        write_bins(REG_BINS_USED_B, nb[CNT_W-1:0]);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata[7:0], s_tdata[23:8]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side; holds off once for a long stretch so the input backs up
    initial begin
        int gap, taken;
        taken = 0;
        forever begin
            gap = pick_gap(m_quiet);
            if (taken == PRESSURE_AFTER) gap = PRESSURE_HOLD;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_WRITE_A;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every bin so no compute ever reads an unwritten one
        for (int k = 0; k < BIN_LIMIT; k++) send_item(OP_WRITE_A, k[IDX_W-1:0], 16'hFFFF);
        for (int k = 0; k < BIN_LIMIT; k++) send_item(OP_WRITE_B, k[IDX_W-1:0], 16'h0000);

        // reset bin counts, widest gap between the histograms
        send_item(OP_COMPUTE, rand_bin(), rand_count());
        send_item(OP_WRITE_A, 8'd0, 16'h0000);
        send_item(OP_WRITE_A, 8'd255, 16'h0000);
        send_item(OP_WRITE_B, 8'd0, 16'hFFFF);
        send_item(OP_WRITE_B, 8'd255, 16'hFFFF);
        send_item(OP_UNUSED, IDX_W'($urandom), BIN_W'($urandom));
        send_item(OP_COMPUTE, rand_bin(), rand_count());

        // no A bins: every shift has an empty overlap, lowest shift wins the tie
        configure(0, 16);
        send_item(OP_COMPUTE, rand_bin(), rand_count());
        // one A bin: positive shifts run past it
        configure(1, 16);
        send_item(OP_COMPUTE, rand_bin(), rand_count());
        // shift range empty
        configure(200, 7);
        send_item(OP_COMPUTE, rand_bin(), rand_count());
        configure(256, 0);
        send_item(OP_COMPUTE, rand_bin(), rand_count());
        // counts above the bin limit clamp to it
        configure(511, 257);
        send_item(OP_WRITE_B, 8'd3, 16'd12345);
        send_item(OP_COMPUTE, rand_bin(), rand_count());

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            int na, nb, r, pct;
            logic [1:0] op;
            if (ph == 4) begin
                na = $urandom_range(256, 511);
                nb = $urandom_range(248, 511);
                pct = 4;
            end else begin
                r = $urandom_range(0, 9);
                na = (r == 0) ? 0 : (r == 1) ? $urandom_range(65, 511) : $urandom_range(1, 64);
                r = $urandom_range(0, 9);
                nb = (r == 0) ? $urandom_range(0, 7) :
                     (r == 1) ? $urandom_range(65, 160) : $urandom_range(8, 64);
                pct = 12;
            end
            configure(na, nb);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < pct) op = OP_COMPUTE;
                else if (r < pct + 3) op = OP_UNUSED;
                else if (r < 57) op = OP_WRITE_A;
                else op = OP_WRITE_B;
                send_item(op, rand_bin(), rand_count());
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
